// ===== design/mrtu_pkg.sv =====
// Shared types, constants and the CRC-16 step for the Modbus RTU receive framer.
package mrtu_pkg;

  // Item kind carried in the input tuser bit.
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Modbus CRC-16, reflected polynomial.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Configuration register reset values.
  localparam logic [7:0]  SLAVE_ADDR_RST = 8'h01;
  localparam logic [15:0] GAP_TICKS_RST  = 16'd35;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_SLAVE_ADDR = 1'b0,
    CFG_GAP_TICKS  = 1'b1
  } cfg_idx_e;

  // One frame report.
  typedef struct packed {
    logic       overrun;
    logic       frame_valid;
    logic       crc_match;
    logic       address_match;
    logic [7:0] function_code;
    logic [8:0] frame_length;
  } res_t;

  // Advance the CRC over one byte, one bit per shift.
  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== design/mrtu_frame_core.sv =====
// Frame state, gap timer, running CRC and frame report logic.
module mrtu_frame_core import mrtu_pkg::*; #(
  parameter int MAX_FRAME = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        mode_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  slave_addr_i,
  input  logic [15:0] gap_ticks_i,
  output logic        res_hit_o,
  output res_t        res_o
);

  localparam int CW = $clog2(MAX_FRAME + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_FRAME);

  logic          active_q, active_d;
  logic [15:0]   gap_q, gap_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [15:0]   crc_q, crc_d;
  logic [15:0]   lag1_q, lag1_d;
  logic [15:0]   lag2_q, lag2_d;
  logic [7:0]    last_q, last_d;
  logic [7:0]    prev_q, prev_d;
  logic [7:0]    first_q, first_d;
  logic [7:0]    second_q, second_d;
  logic          ovr_q, ovr_d;

  logic          is_byte;
  logic          start;
  logic          store;
  logic          tick_hit;
  logic [15:0]   gap_dec;
  logic [CW-1:0] cnt_base;
  logic [15:0]   crc_base;
  logic [15:0]   lag1_base;
  logic [7:0]    second_base;
  logic          has_two;
  logic          am;
  logic          cm;

  // Decode the item against the current frame state.
  assign is_byte  = (mode_i == MODE_BYTE);
  assign start    = is_byte && !active_q;
  assign store    = is_byte && (!active_q || (cnt_q < CNT_MAX));
  assign tick_hit = !is_byte && active_q;
  assign gap_dec  = (gap_q != 16'd0) ? (gap_q - 16'd1) : 16'd0;
  assign res_hit_o = tick_hit && (gap_dec == 16'd0);

  // A new frame restarts count, CRC chain and overrun.
  assign cnt_base    = start ? '0 : cnt_q;
  assign crc_base    = start ? CRC_INIT : crc_q;
  assign lag1_base   = start ? CRC_INIT : lag1_q;
  assign second_base = start ? 8'h00 : second_q;

  // Next state.
  always_comb begin
    active_d = active_q;
    gap_d    = gap_q;
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    lag1_d   = lag1_q;
    lag2_d   = lag2_q;
    last_d   = last_q;
    prev_d   = prev_q;
    first_d  = first_q;
    second_d = second_q;
    ovr_d    = ovr_q;
    if (store) begin
      if (cnt_base == '0) begin
        first_d = rx_byte_i;
      end
      second_d = (cnt_base == CW'(1)) ? rx_byte_i : second_base;
      prev_d   = last_q;
      last_d   = rx_byte_i;
      lag2_d   = lag1_base;
      lag1_d   = crc_base;
      crc_d    = crc16_step(crc_base, rx_byte_i);
      cnt_d    = cnt_base + CW'(1);
      gap_d    = gap_ticks_i;
      active_d = 1'b1;
      ovr_d    = start ? 1'b0 : ovr_q;
    end else if (is_byte) begin
      ovr_d = 1'b1;
    end else if (tick_hit) begin
      gap_d = gap_dec;
      if (res_hit_o) begin
        active_d = 1'b0;
      end
    end
  end

  // Frame report from the state as it stands when the gap runs out.
  assign has_two = (cnt_q > CW'(1));
  assign am = (cnt_q != '0) && (first_q == slave_addr_i);
  assign cm = has_two && ({prev_q, last_q} == {lag2_q[7:0], lag2_q[15:8]});

  always_comb begin
    res_o.frame_length  = 9'(cnt_q);
    res_o.function_code = has_two ? second_q : 8'h00;
    res_o.address_match = am;
    res_o.crc_match     = cm;
    res_o.frame_valid   = am && cm && (cnt_q > CW'(2));
    res_o.overrun       = ovr_q;
  end

  // State registers, updated once per processed item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      gap_q    <= 16'd0;
      cnt_q    <= '0;
      crc_q    <= CRC_INIT;
      lag1_q   <= CRC_INIT;
      lag2_q   <= CRC_INIT;
      last_q   <= 8'h00;
      prev_q   <= 8'h00;
      first_q  <= 8'h00;
      second_q <= 8'h00;
      ovr_q    <= 1'b0;
    end else if (step_i) begin
      active_q <= active_d;
      gap_q    <= gap_d;
      cnt_q    <= cnt_d;
      crc_q    <= crc_d;
      lag1_q   <= lag1_d;
      lag2_q   <= lag2_d;
      last_q   <= last_d;
      prev_q   <= prev_d;
      first_q  <= first_d;
      second_q <= second_d;
      ovr_q    <= ovr_d;
    end
  end

  // The stored count never passes the frame capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_MAX)
    else $error("byte count beyond frame capacity");

  // A report only comes out of an open frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_hit_o |-> active_q)
    else $error("frame report outside a frame");

  // A processed report closes the frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res_hit_o) |=> !active_q)
    else $error("frame still open after its report");

  // A byte that arrives at full capacity flags overrun and keeps the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && is_byte && active_q && (cnt_q == CNT_MAX)) |=> (ovr_q && (cnt_q == CNT_MAX)))
    else $error("overrun not flagged on a full frame");

endmodule

// ===== design/mrtu_out_reg.sv =====
// Result register holding one frame report until the downstream side takes it.
module mrtu_out_reg import mrtu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic ready_i,
  output logic valid_o,
  output res_t res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  // A load always wins; otherwise a taken beat empties the register.
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== design/modbus_rtu_frame_receiver.sv =====
// Beats pass the input register, then the frame core; a report goes to the output register.
// Throughput: one byte or tick beat per cycle, the CRC-16 one byte, unless the output stalls.
// The input register refills in the same cycle it drains unless a report is stuck at the output.
// Reset (rst_ni low, asynchronous) closes any frame, stops the gap timer, sets the CRC to 0xFFFF,
// and sets slave address 1 and frame gap 35 ticks.
// No clearing pass: the block takes beats as soon as reset is released.
module modbus_rtu_frame_receiver import mrtu_pkg::*; #(
  parameter int MAX_FRAME = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] mode
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [8:0] frame_length, [16:9] function_code,
                                      // [17] address_match, [18] crc_match,
                                      // [19] frame_valid, [20] overrun, [23:21] zero
);

  logic        in_valid_q;
  logic        in_mode_q;
  logic [7:0]  in_byte_q;
  logic [7:0]  slave_addr_q;
  logic [15:0] gap_ticks_q;
  logic        res_hit;
  logic        advance;
  logic        out_valid;
  res_t        core_res;
  res_t        out_res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= SLAVE_ADDR_RST;
      gap_ticks_q  <= GAP_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SLAVE_ADDR: slave_addr_q <= cfg_data_i[7:0];
        CFG_GAP_TICKS:  gap_ticks_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The held beat moves on unless it makes a report and the output is full.
  assign advance       = in_valid_q && (!res_hit || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_mode_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  mrtu_frame_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .mode_i       (in_mode_q),
    .rx_byte_i    (in_byte_q),
    .slave_addr_i (slave_addr_q),
    .gap_ticks_i  (gap_ticks_q),
    .res_hit_o    (res_hit),
    .res_o        (core_res)
  );

  mrtu_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && res_hit),
    .res_i   (core_res),
    .ready_i (m_axis_tready),
    .valid_o (out_valid),
    .res_o   (out_res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_res};

endmodule

// ===== tb/modbus_rtu_frame_receiver_tb.sv =====
// Self-checking testbench for the Modbus RTU receive framer, predicting each frame report.
module modbus_rtu_frame_receiver_tb;
  import mrtu_pkg::*;

  localparam int MAX_FRAME     = 256;
  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT   = 1000;

  typedef logic [7:0] octet_t;
  typedef octet_t octets_t[$];

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        s_axis_tuser;   // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [23:0] m_axis_tdata;   // [8:0] frame_length, [16:9] function_code,
                               // [17] address_match, [18] crc_match,
                               // [19] frame_valid, [20] overrun, [23:21] zero

  bit idle_on = 1'b1;
  int stall_left = 0;
  int beats_sent = 0;
  int n_errors = 0;
  int quiet_cycles = 0;

  // Expected frame reports, oldest first.
  res_t frame_reports[$];

  // Framer state as the testbench sees it.
  logic [7:0]  mdl_addr;
  logic [15:0] mdl_gap;
  bit          frm_open;
  bit          tmr_on;
  logic [15:0] gap_left;
  int          nbytes;
  logic [15:0] crc_now;
  logic [15:0] crc_d1;
  logic [15:0] crc_d2;
  logic [7:0]  byte_last;
  logic [7:0]  byte_prev;
  logic [7:0]  byte_first;
  logic [7:0]  byte_second;
  bit          ovr_seen;

  modbus_rtu_frame_receiver #(
    .MAX_FRAME(MAX_FRAME)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Modbus CRC-16, fed one data bit at a time, LSB first.
  function automatic logic [15:0] crc_advance(logic [15:0] acc, logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  // Append the CRC to a frame body, low byte first as on the wire.
  function automatic octets_t seal(octets_t body);
    octets_t     q;
    logic [15:0] c;
    q = body;
    c = CRC_INIT;
    foreach (body[i]) c = crc_advance(c, body[i]);
    q.push_back(c[7:0]);
    q.push_back(c[15:8]);
    return q;
  endfunction

  function automatic void model_reset();
    mdl_addr    = SLAVE_ADDR_RST;
    mdl_gap     = GAP_TICKS_RST;
    frm_open    = 1'b0;
    tmr_on      = 1'b0;
    gap_left    = '0;
    nbytes      = 0;
    crc_now     = CRC_INIT;
    crc_d1      = CRC_INIT;
    crc_d2      = CRC_INIT;
    byte_last   = '0;
    byte_prev   = '0;
    byte_first  = '0;
    byte_second = '0;
    ovr_seen    = 1'b0;
  endfunction

  function automatic void store_octet(logic [7:0] b);
    if (nbytes == 0) byte_first = b;
    else if (nbytes == 1) byte_second = b;
    byte_prev = byte_last;
    byte_last = b;
    crc_d2    = crc_d1;
    crc_d1    = crc_now;
    crc_now   = crc_advance(crc_now, b);
    nbytes++;
    gap_left  = mdl_gap;
    tmr_on    = 1'b1;
  endfunction

  // Apply one accepted beat; a frame that ends here adds a report.
  function automatic void advance_framer(logic mode, logic [7:0] b);
    res_t r;
    logic [15:0] wire_crc;
    if (mode == MODE_BYTE) begin
      if (!frm_open) begin
        frm_open    = 1'b1;
        nbytes      = 0;
        crc_now     = CRC_INIT;
        crc_d1      = CRC_INIT;
        crc_d2      = CRC_INIT;
        ovr_seen    = 1'b0;
        byte_second = '0;
        store_octet(b);
      end else if (nbytes < MAX_FRAME) begin
        store_octet(b);
      end else begin
        ovr_seen = 1'b1;
      end
    end else if (tmr_on) begin
      if (gap_left != 0) gap_left--;
      if (gap_left == 0) begin
        tmr_on = 1'b0;
        if (frm_open) begin
          frm_open = 1'b0;
          // The CRC two bytes back covers everything but the trailing CRC field.
          wire_crc          = {crc_d2[7:0], crc_d2[15:8]};
          r.frame_length    = 9'(nbytes);
          r.function_code   = (nbytes >= 2) ? byte_second : 8'h00;
          r.address_match   = (nbytes >= 1) && (byte_first == mdl_addr);
          r.crc_match       = (nbytes >= 2) && ({byte_prev, byte_last} == wire_crc);
          r.frame_valid     = r.address_match && r.crc_match && (nbytes >= 3);
          r.overrun         = ovr_seen;
          frame_reports.push_back(r);
        end
      end
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Check reports leaving the block, then follow config writes and input beats.
  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      model_reset();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata[20:0]);
        if (frame_reports.size() == 0) begin
          report_mismatch($sformatf("report with none expected, length %0d",
                                    got.frame_length));
        end else begin
          want = frame_reports.pop_front();
          check_field("frame_length", got.frame_length, want.frame_length);
          check_field("function_code", got.function_code, want.function_code);
          check_field("address_match", got.address_match, want.address_match);
          check_field("crc_match", got.crc_match, want.crc_match);
          check_field("frame_valid", got.frame_valid, want.frame_valid);
          check_field("overrun", got.overrun, want.overrun);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SLAVE_ADDR: mdl_addr = cfg_data_i[7:0];
          CFG_GAP_TICKS:  mdl_gap  = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) advance_framer(s_axis_tuser, s_axis_tdata);
    end
  end

  // Receiver stalls in random bursts, only while idling is enabled.
  always @(negedge clk_i) begin
    if (!idle_on) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog: too long without any beat on either side ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Send one beat, with an optional idle burst before it; returns at a falling edge.
  task automatic send_beat(logic mode, logic [7:0] data);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    beats_sent++;
  endtask

  task automatic send_tick();
    send_beat(MODE_TICK, 8'($urandom));
  endtask

  // Enough ticks to run the gap counter out.
  task automatic close_frame();
    repeat ((mdl_gap == 0) ? 1 : int'(mdl_gap)) send_tick();
  endtask

  // Send a frame, optionally with short tick runs between bytes, then close it.
  task automatic send_frame(octets_t q, bit pauses);
    foreach (q[i]) begin
      if (pauses && i != 0 && mdl_gap > 1 && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, int'(mdl_gap) - 1)) send_tick();
      send_beat(MODE_BYTE, q[i]);
    end
    close_frame();
  endtask

  // Stop sending and let every expected report come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (frame_reports.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  // Reset values: station 1, 35-tick gap.
  task automatic test_reset_defaults();
    send_frame(seal('{8'h01, 8'h03, 8'h00, 8'h6B}), 1'b0);
    send_frame(seal('{8'h02, 8'h04}), 1'b0);
  endtask

  // Ticks while idle, and frames of one, two, three and five bytes.
  task automatic test_short_frames();
    write_reg(CFG_SLAVE_ADDR, 16'h0000);
    write_reg(CFG_GAP_TICKS, 16'd1);
    send_tick();
    send_tick();
    send_frame('{8'h00}, 1'b0);
    // With two bytes the CRC over nothing is all ones.
    send_frame('{8'hFF, 8'hFF}, 1'b0);
    send_frame('{8'h00, 8'h12}, 1'b0);
    send_frame(seal('{8'h00}), 1'b0);
    send_frame(seal('{8'hFF, 8'h00, 8'hFF}), 1'b0);
  endtask

  // Zero gap, a gap interrupted by a byte, and the largest gap.
  task automatic test_gap_extremes();
    octets_t q;
    write_reg(CFG_GAP_TICKS, 16'd0);
    send_beat(MODE_BYTE, 8'h00);
    send_beat(MODE_BYTE, 8'h55);
    send_tick();
    write_reg(CFG_GAP_TICKS, 16'd3);
    write_reg(CFG_SLAVE_ADDR, 16'hA5FF);
    q = seal('{8'hFF, 8'h06, 8'h00, 8'h01});
    send_beat(MODE_BYTE, q[0]);
    send_tick();
    send_tick();
    for (int i = 1; i < q.size(); i++) send_beat(MODE_BYTE, q[i]);
    close_frame();
    write_reg(CFG_GAP_TICKS, 16'hFFFF);
    q = seal('{8'hFF, 8'h10, 8'hAA});
    send_beat(MODE_BYTE, q[0]);
    send_beat(MODE_BYTE, q[1]);
    // The largest gap keeps the frame open through a run of ticks.
    repeat (20) send_tick();
    // A shorter gap takes effect at the next byte of the open frame.
    write_reg(CFG_GAP_TICKS, 16'd3);
    for (int i = 2; i < q.size(); i++) send_beat(MODE_BYTE, q[i]);
    close_frame();
  endtask

  // A full frame, an overlong one whose extra bytes are dropped, then a clean one.
  task automatic test_overrun();
    octets_t q;
    write_reg(CFG_GAP_TICKS, 16'd2);
    write_reg(CFG_SLAVE_ADDR, 16'h0011);
    q = '{8'h11, 8'h03};
    repeat (MAX_FRAME - 4) q.push_back(8'($urandom));
    send_frame(seal(q), 1'b0);
    repeat (MAX_FRAME + 20) send_beat(MODE_BYTE, 8'($urandom));
    // Dropped bytes do not reload the gap counter.
    send_tick();
    repeat (4) send_beat(MODE_BYTE, 8'($urandom));
    send_tick();
    send_frame(seal('{8'h11, 8'h01}), 1'b0);
  endtask

  // One random stretch: mostly well-formed frames, some corrupted, some noise.
  task automatic random_burst();
    octets_t q;
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      q.push_back(($urandom_range(0, 3) != 0) ? mdl_addr : 8'($urandom));
      n = $urandom_range(0, 8);
      repeat (n + 1) q.push_back(8'($urandom));
      q = seal(q);
      if (kind >= 70) begin
        n = $urandom_range(0, q.size() - 1);
        q[n] = q[n] ^ 8'(1 << $urandom_range(0, 7));
      end
      send_frame(q, 1'b1);
    end else begin
      repeat ($urandom_range(1, 6)) send_beat(1'($urandom), 8'($urandom));
      close_frame();
    end
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) send_tick();
  endtask

  // Random traffic over several settings; the last phase runs without idling.
  task automatic test_random_traffic();
    int          target;
    logic [7:0]  addr;
    logic [15:0] gap;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin addr = 8'h00; gap = 16'd1; end
        1: begin addr = 8'hFF; gap = 16'd2; end
        2: begin addr = 8'($urandom); gap = 16'd5; end
        3: begin addr = 8'($urandom); gap = 16'($urandom_range(1, 8)); end
        default: begin addr = 8'($urandom); gap = 16'd3; end
      endcase
      write_reg(CFG_SLAVE_ADDR, {8'($urandom), addr});
      write_reg(CFG_GAP_TICKS, gap);
      idle_on = (ph != 4);
      target = beats_sent + 100;
      while (beats_sent < target) random_burst();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_SLAVE_ADDR;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = MODE_BYTE;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_short_frames();
    test_gap_extremes();
    test_overrun();
    test_random_traffic();

    wait_drained();
    if (frame_reports.size() != 0)
      report_mismatch($sformatf("%0d reports never arrived", frame_reports.size()));
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
